/* rtl/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// shared item types and action codes for the piecewise linear lookup
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int unsigned COUNT_W = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned DATA_W  = 32;

    typedef struct packed {
        logic                      action;
        logic [INDEX_W-1:0]        point_index;
        logic signed [DATA_W-1:0]  x_in;
        logic signed [DATA_W-1:0]  y_in;
    } t_pwl_in;

    typedef struct packed {
        logic signed [DATA_W-1:0]  y_out;
        logic                      in_range;
    } t_pwl_out;

    typedef struct packed {
        logic                      start;
        logic                      done;
    } t_div_ctl;

endpackage

/* rtl/pwl_mem.sv */
// ----------------------------------------------------------------------------
// pwl_mem
// point table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pwl_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [2*pwl_pkg::DATA_W-1:0]      i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [2*pwl_pkg::DATA_W-1:0]      o_rd_data
);

    logic [2*pwl_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [2*pwl_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/pwl_div.sv */
// ----------------------------------------------------------------------------
// pwl_div
// restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module pwl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_dividend,
    input  logic [31:0]       i_divisor,
    output logic              o_done,
    output logic [31:0]       o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] n_trial;
    logic [32:0] n_diff;
    logic        n_bit;

    always_comb begin
        n_trial = {r_rem, r_quo[63]};
        n_diff  = n_trial - {1'b0, r_div};
        n_bit   = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so 32 bits hold it
                r_rem <= n_bit ? n_diff[31:0] : n_trial[31:0];
                r_quo <= {r_quo[62:0], n_bit};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[31:0];

endmodule

/* rtl/piecewise_linear_lookup.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_lookup
// table of signed q16.16 points with linear interpolation between neighbors
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (pwl_pkg::t_pwl_in)
//  out     | output    | o_out_valid / i_out_ready | o_out (pwl_pkg::t_pwl_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (point count)
//
//  a write item gives no result
//  a query item first scans up to the n table points in use, reading one entry a
//  cycle from the table memory; an in-range query then passes the difference,
//  multiply and load states and the 64-step divider; every query ends in the
//  final state, and an empty table goes there straight from acceptance
//  reset clears the point count, the state, the output valid flag and the scan
//  index and read flag; table contents stay undefined until written
//  the output register holds a finished result while a new item is accepted;
//  a further result waits in the final state until the register drains
//
module piecewise_linear_lookup #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pwl_pkg::t_pwl_in                  i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pwl_pkg::t_pwl_out                 o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pwl_pkg::COUNT_W-1:0]       i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DIFF, S_MUL, S_LOAD, S_DIV, S_SUM
    } t_state;

    t_state r_state;

    logic [pwl_pkg::COUNT_W-1:0] r_count;
    logic [CW-1:0]               n_neff;

    // scan bookkeeping
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_kidx;
    logic [CW-1:0]  r_n;
    logic           r_dval;
    logic           n_issue;

    // operands
    logic signed [31:0] r_q, r_x0, r_y0, r_x1, r_y1;
    logic [31:0]        r_mag, r_dq, r_dx;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_quot;
    logic               r_inr;

    // output register
    logic               r_out_valid;
    pwl_pkg::t_pwl_out  r_out;

    // memory wiring
    logic                          n_wr_en;
    logic [2*pwl_pkg::DATA_W-1:0]  n_rd_data;
    logic signed [31:0]            n_rd_x, n_rd_y;

    // arithmetic
    logic signed [32:0] n_dy, n_dq, n_dx;
    logic signed [33:0] n_sum;
    logic signed [31:0] n_sat;

    pwl_pkg::t_div_ctl  n_div;
    logic [31:0]        n_div_q;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a count beyond capacity acts as full capacity
    always_comb begin
        if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_neff = CW'(MAX_POINTS);
        end else begin
            n_neff = CW'(r_count);
        end
    end

    assign n_wr_en = i_in_valid && o_in_ready && (i_in.action == pwl_pkg::ACT_WRITE)
                     && (32'(i_in.point_index) < 32'(MAX_POINTS));
    assign n_issue = (r_state == S_SCAN) && (r_idx < r_n);

    pwl_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (AW'(i_in.point_index)),
        .i_wr_data ({i_in.x_in, i_in.y_in}),
        .i_rd_en   (n_issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (n_rd_data)
    );

    assign n_rd_x = n_rd_data[63:32];
    assign n_rd_y = n_rd_data[31:0];

    // exact differences; dq and dx are known non-negative once a bracket is found
    always_comb begin
        n_dy = 33'(r_y1) - 33'(r_y0);
        n_dq = 33'(r_q)  - 33'(r_x0);
        n_dx = 33'(r_x1) - 33'(r_x0);
    end

    // divider loads the product once it sits in its register
    assign n_div.start = (r_state == S_LOAD);

    pwl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div.start),
        .i_dividend (r_prod),
        .i_divisor  (r_dx),
        .o_done     (n_div.done),
        .o_quotient (n_div_q)
    );

    // quotient magnitude never exceeds |dy|, so the sum fits 34 bits
    always_comb begin
        if (r_neg) begin
            n_sum = 34'(r_y0) - $signed({2'b00, r_quot});
        end else begin
            n_sum = 34'(r_y0) + $signed({2'b00, r_quot});
        end
        if (n_sum > 34'sd2147483647) begin
            n_sat = 32'sh7fffffff;
        end else if (n_sum < -34'sd2147483648) begin
            n_sat = 32'sh80000000;
        end else begin
            n_sat = n_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dval      <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            // the final state reloads the register whenever it drains
            if (i_out_ready && r_state != S_SUM) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_in.action == pwl_pkg::ACT_QUERY) begin
                        r_q    <= i_in.x_in;
                        r_n    <= n_neff;
                        r_idx  <= '0;
                        r_dval <= 1'b0;
                        r_inr  <= 1'b0;
                        // empty table goes straight to the final state and answers out of range
                        r_state <= (n_neff == '0) ? S_SUM : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, check the entry read last cycle
                    if (n_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_dval <= n_issue;
                    r_kidx <= r_idx;
                    if (r_dval) begin
                        if (n_rd_x > r_q) begin
                            r_x1   <= n_rd_x;
                            r_y1   <= n_rd_y;
                            if (r_kidx == '0) begin
                                r_inr   <= 1'b0;
                                r_state <= S_SUM;
                            end else begin
                                r_inr   <= 1'b1;
                                r_state <= S_DIFF;
                            end
                        end else begin
                            r_x0 <= n_rd_x;
                            r_y0 <= n_rd_y;
                            // no entry above the query
                            if (r_kidx == r_n - 1'b1) begin
                                r_inr   <= 1'b0;
                                r_state <= S_SUM;
                            end
                        end
                    end
                end
                S_DIFF: begin
                    r_neg   <= n_dy[32];
                    r_mag   <= n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
                    r_dq    <= n_dq[31:0];
                    r_dx    <= n_dx[31:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 64'(r_mag) * 64'(r_dq);
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_div.done) begin
                        r_quot  <= n_div_q;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out.in_range <= r_inr;
                        r_out.y_out    <= r_inr ? n_sat : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // a result out of range always carries zero
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.in_range |-> o_out.y_out == '0)
        else $error("out of range result is not zero");

    // a write item never raises a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.action == pwl_pkg::ACT_WRITE && !o_out_valid
        |=> !o_out_valid)
        else $error("write item produced a result");

    // divider finishes only while the query waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_div.done |-> r_state == S_DIV)
        else $error("divider done outside divide state");
`endif

endmodule

/* verif/tb_piecewise_linear_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_lookup
// self-checking regression for the piecewise linear lookup table
// ----------------------------------------------------------------------------
//
//  a queue of pending items feeds a clocked driver; accepted writes update a
//  local interpolation predictor and each query pushes one expected result;
//  a clocked monitor pops and compares every accepted result
//  the point count is only changed once the block has gone quiet
//
module tb_piecewise_linear_lookup;

    localparam int  NPTS      = 64;
    localparam int  SETTLE    = 200;
    localparam int  LIMIT     = 1000000;
    localparam int  HOLD_LEN  = 600;
    localparam longint S_MIN  = -64'sd2147483648;
    localparam longint S_MAX  = 64'sd2147483647;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    pwl_pkg::t_pwl_in            i_in = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    pwl_pkg::t_pwl_out           o_out;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [pwl_pkg::COUNT_W-1:0] i_cfg_data = '0;

    piecewise_linear_lookup #(.MAX_POINTS(NPTS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stimulus queues, predictor state and scoreboard
    pwl_pkg::t_pwl_in            pending_items[$];
    logic [pwl_pkg::COUNT_W-1:0] pending_counts[$];
    pwl_pkg::t_pwl_out           expected_results[$];

    logic signed [pwl_pkg::DATA_W-1:0] tbl_x [NPTS];
    logic signed [pwl_pkg::DATA_W-1:0] tbl_y [NPTS];
    logic [pwl_pkg::COUNT_W-1:0]       count_pred = '0;

    // generator view of the table x values, used to aim queries
    longint gen_x [NPTS];

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;

    int errors = 0;
    int items_made = 0;
    int writes_seen = 0;
    int queries_seen = 0;
    int in_range_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;

    // expected answer of a query against the current table and count
    function automatic pwl_pkg::t_pwl_out interpolate(logic signed [pwl_pkg::DATA_W-1:0] q);
        pwl_pkg::t_pwl_out res;
        int n;
        int j;
        bit found;
        longint x0, x1, y0, y1, dy, dq, dx, quo, total;
        longint unsigned mag, prod;
        res = '0;
        n = (count_pred > NPTS) ? NPTS : int'(count_pred);
        found = 1'b0;
        j = 0;
        while (j < n && !found) begin
            if (tbl_x[j] > q)
                found = 1'b1;
            else
                j++;
        end
        if (!found || j == 0)
            return res;
        x0 = tbl_x[j-1];
        x1 = tbl_x[j];
        y0 = tbl_y[j-1];
        y1 = tbl_y[j];
        dy = y1 - y0;
        dq = longint'(q) - x0;
        dx = x1 - x0;
        mag = (dy < 0) ? longint'(-dy) : dy;
        prod = mag * longint'(dq);
        quo = longint'(prod / longint'(dx));
        if (dy < 0)
            quo = -quo;
        total = y0 + quo;
        if (total > S_MAX)
            total = S_MAX;
        if (total < S_MIN)
            total = S_MIN;
        res.y_out = total[pwl_pkg::DATA_W-1:0];
        res.in_range = 1'b1;
        return res;
    endfunction

    // driver: holds an item until taken, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_in.action == pwl_pkg::ACT_WRITE) begin
                    tbl_x[i_in.point_index] = i_in.x_in;
                    tbl_y[i_in.point_index] = i_in.y_in;
                    writes_seen++;
                end else begin
                    expected_results.push_back(interpolate(i_in.x_in));
                    queries_seen++;
                end
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_in <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // point count writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                count_pred = i_cfg_data;
                cfg_writes++;
            end
            if (!(i_cfg_valid && !o_cfg_ready)) begin
                if (pending_counts.size() != 0) begin
                    i_cfg_data <= pending_counts.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the monitor only reads it
    always @(posedge i_clk) begin
        if (hold_reqs != hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= hold_done + 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: random backpressure and result check
    always @(posedge i_clk) begin
        pwl_pkg::t_pwl_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result y_out=%0d in_range=%0b",
                                 o_out.y_out, o_out.in_range);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.in_range)
                        in_range_seen++;
                    if (o_out.y_out !== want.y_out || o_out.in_range !== want.in_range) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: y_out exp %0d got %0d, in_range exp %0b got %0b",
                                     want.y_out, o_out.y_out, want.in_range, o_out.in_range);
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("piecewise_linear_lookup regression: fail");
            $finish;
        end
    end

    task automatic push_write(int idx, longint x, longint y);
        pwl_pkg::t_pwl_in it;
        it.action = pwl_pkg::ACT_WRITE;
        it.point_index = idx[pwl_pkg::INDEX_W-1:0];
        it.x_in = x[pwl_pkg::DATA_W-1:0];
        it.y_in = y[pwl_pkg::DATA_W-1:0];
        pending_items.push_back(it);
        gen_x[idx] = longint'(it.x_in);
        items_made++;
    endtask

    task automatic push_query(longint q);
        pwl_pkg::t_pwl_in it;
        it.action = pwl_pkg::ACT_QUERY;
        it.point_index = pwl_pkg::INDEX_W'($urandom);
        it.x_in = q[pwl_pkg::DATA_W-1:0];
        it.y_in = $urandom;
        pending_items.push_back(it);
        items_made++;
    endtask

    // waits until every item is taken and every result has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_count(int value);
        wait_drained();
        pending_counts.push_back(value[pwl_pkg::COUNT_W-1:0]);
        while (pending_counts.size() != 0 || i_cfg_valid)
            @(negedge i_clk);
    endtask

    function automatic longint rand_y();
        case ($urandom_range(9))
            0: return S_MIN;
            1: return S_MAX;
            default: return longint'(int'($urandom));
        endcase
    endfunction

    // ascending x values, span and spacing picked at random
    task automatic build_sorted(int n);
        longint x, span;
        x = ($urandom_range(3) == 0) ? S_MIN : S_MIN + longint'($urandom_range(0, 32'hC000_0000));
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                span = (S_MAX - x) / (n - i);
                if ($urandom_range(1))
                    span = span >> $urandom_range(0, 24);
                if (span < 1)
                    span = 1;
                x = x + 1 + longint'($urandom) % span;
            end
            push_write(i, x, rand_y());
        end
    endtask

    // mostly between two neighbors, some on points, below, above or anywhere
    task automatic push_aimed(int n);
        int r, k;
        longint lo, hi;
        r = $urandom_range(99);
        if (n < 2 || r >= 90) begin
            push_query(longint'(int'($urandom)));
        end else if (r < 70) begin
            k = $urandom_range(0, n - 2);
            lo = gen_x[k];
            hi = gen_x[k+1];
            push_query(hi > lo ? lo + longint'($urandom) % (hi - lo) : lo);
        end else if (r < 80) begin
            push_query(gen_x[$urandom_range(0, n - 1)]);
        end else if (r < 85) begin
            push_query(gen_x[0] - 1 > S_MIN ? gen_x[0] - 1 : S_MIN);
        end else begin
            push_query(r[0] ? S_MAX : S_MIN);
        end
    endtask

    initial begin
        int n, cnt_val, target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table after reset
        push_query(0);
        push_query(S_MIN);
        push_query(S_MAX);

        // full-range ascending table, extreme y values, every entry written
        for (int i = 0; i < NPTS; i++)
            push_write(i, S_MIN + (longint'(i) * (S_MAX - S_MIN)) / (NPTS - 1),
                       i[0] ? S_MAX : S_MIN);
        set_count(NPTS);
        push_query(S_MIN);
        push_query(S_MIN + 1);
        push_query(0);
        push_query(gen_x[31] + 7);
        push_query(S_MAX - 1);
        push_query(S_MAX);
        set_count(1);
        push_query(S_MIN);
        push_query(S_MAX);
        set_count(2);
        push_query(gen_x[0] + 12345);
        set_count(100);
        push_query(gen_x[62] + 99);
        set_count(127);
        push_query(0);
        set_count(0);
        push_query(0);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int m = 0; m < 4; m++) begin
            idle_pct  = (m == 1) ? 57 : (m == 3) ? 30 : 0;
            stall_pct = (m == 2) ? 57 : (m == 3) ? 30 : 0;
            target = 25 + (m + 1) * 132;
            while (items_made < target) begin
                case ($urandom_range(19))
                    0, 1:    n = NPTS;
                    2:       n = 0;
                    3:       n = 1;
                    default: n = $urandom_range(2, 12);
                endcase
                cnt_val = (n == NPTS && $urandom_range(1)) ? $urandom_range(65, 127) : n;
                set_count(cnt_val);
                if ($urandom_range(6) == 0) begin
                    for (int i = 0; i < n; i++)
                        push_write(i, longint'(int'($urandom)), rand_y());
                end else begin
                    build_sorted(n);
                end
                // first table of the first phase: results back up behind a hold-off
                if (m == 0 && hold_reqs == 0)
                    hold_reqs = 1;
                for (int k = 0; k < 30; k++) begin
                    if ($urandom_range(9) == 0)
                        push_write($urandom_range(0, NPTS - 1),
                                   longint'(int'($urandom)), rand_y());
                    else
                        push_aimed(n > NPTS ? NPTS : n);
                end
            end
        end

        wait_drained();
        if (expected_results.size() != 0)
            errors++;
        $display("covered %0d writes and %0d queries (%0d interpolated), %0d count writes",
                 writes_seen, queries_seen, in_range_seen, cfg_writes);
        $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
        if (errors == 0) begin
            $display("piecewise_linear_lookup regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("piecewise_linear_lookup regression: fail");
        end
        $finish;
    end

endmodule
